>>> rtl/a555_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a555_pkg
// Shared types and constants for the 555 astable oscillator unit.
// ----------------------------------------------------------------------------
package a555_pkg;

    localparam logic [15:0] SILENCE_LEVEL = 16'd20480;
    localparam logic [29:0] LN2_Q30       = 30'd744261118;
    localparam logic [29:0] NS_PER_S      = 30'd1000000000;
    localparam int          LOG_FRAC      = 24;
    localparam int          SQR_LAST      = LOG_FRAC - 1;
    localparam int          DUTY_LAST     = 15;

    // register indexes on the configuration port
    localparam logic [2:0] REG_CHARGE    = 3'd0;
    localparam logic [2:0] REG_DISCHARGE = 3'd1;
    localparam logic [2:0] REG_RATE      = 3'd2;
    localparam logic [2:0] REG_AMPLITUDE = 3'd3;
    localparam logic [2:0] REG_ENABLE    = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_NORM_NUM,
        ST_SQR_NUM,
        ST_LOAD_DEN,
        ST_NORM_DEN,
        ST_SQR_DEN,
        ST_LN_MUL,
        ST_HIGH_MUL,
        ST_TOTAL,
        ST_DUTY_CHK,
        ST_DUTY_DIV,
        ST_D_MUL,
        ST_PDIV,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic load_num;
        logic load_den;
        logic norm_step;
        logic sqr_init;
        logic sqr_step;
        logic ln_mul;
        logic high_mul;
        logic total_add;
        logic duty_init;
        logic duty_full;
        logic duty_step;
        logic d_mul;
        logic div_step;
        logic commit;
        logic silence;
        logic tick;
    } cmd_t;

    typedef struct packed {
        logic cv_changed;
        logic cv_silent;
        logic norm_done;
        logic cnt_zero;
        logic total_bad;
        logic high_full;
    } stat_t;

endpackage

>>> rtl/astable_555_oscillator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// astable_555_oscillator_unit
// Square-wave source after a 555 timer in astable mode, steered by a
// control voltage; register file on an APB-style port.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  s_       | in        | s_valid / s_ready     | s_opcode, s_control_voltage
//  m_       | out       | m_valid / m_ready     | m_sample
//  apb      | in        | psel, penable, pready | paddr, pwdata, prdata
//
//  A tick's sample is registered and shows on m_sample in the cycle after
//  the transfer. A control-voltage change holds the input while the
//  recompute runs; at the default supply level it takes 15 or 16 normalise
//  steps for the numerator and 15 to 29 for the denominator, 24 squarings
//  per log2 pass on one 31x31 multiplier, 16 duty divide steps (none when
//  the low time is zero), 30 + PHASE_BITS phase-step divide steps and ten
//  other steps. An ignored or repeated voltage starts no recompute, and a
//  silent one only passes the check step before the input is free again.
//  Reset is synchronous and active low; it clears waveform state and
//  loads the register defaults.
//  Inputs stall while a sample waits on m_ready or a recompute runs.
// ----------------------------------------------------------------------------
module astable_555_oscillator_unit
    import a555_pkg::*;
#(
    parameter int PHASE_BITS   = 32,
    parameter int SUPPLY_LEVEL = 20480
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_opcode,
    input  logic [15:0]        s_control_voltage,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_sample,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [26:0] charge_reg, charge_next;
    logic [26:0] discharge_reg, discharge_next;
    logic [17:0] rate_reg, rate_next;
    logic [14:0] amp_reg, amp_next;
    logic        enable_reg, enable_next;
    logic        wr;
    logic [2:0]  idx;
    cmd_t        cmd;
    stat_t       stat;

    // zero-wait port: every access completes in its access cycle
    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            charge_reg    <= 27'd5700000;
            discharge_reg <= 27'd693147;
            rate_reg      <= 18'd48000;
            amp_reg       <= 15'd328;
            enable_reg    <= 1'b0;
        end else begin
            charge_reg    <= charge_next;
            discharge_reg <= discharge_next;
            rate_reg      <= rate_next;
            amp_reg       <= amp_next;
            enable_reg    <= enable_next;
        end
    end

    // write decode; addresses beyond the register list are dropped
    always_comb begin
        charge_next    = charge_reg;
        discharge_next = discharge_reg;
        rate_next      = rate_reg;
        amp_next       = amp_reg;
        enable_next    = enable_reg;
        if (wr) begin
            unique case (idx)
                REG_CHARGE:    charge_next    = pwdata[26:0];
                REG_DISCHARGE: discharge_next = pwdata[26:0];
                REG_RATE:      rate_next      = pwdata[17:0];
                REG_AMPLITUDE: amp_next       = pwdata[14:0];
                REG_ENABLE:    enable_next    = pwdata[0];
                default:       ;
            endcase
        end
    end

    // read decode
    always_comb begin
        unique case (idx)
            REG_CHARGE:    prdata = {5'd0, charge_reg};
            REG_DISCHARGE: prdata = {5'd0, discharge_reg};
            REG_RATE:      prdata = {14'd0, rate_reg};
            REG_AMPLITUDE: prdata = {17'd0, amp_reg};
            REG_ENABLE:    prdata = {31'd0, enable_reg};
            default:       prdata = '0;
        endcase
    end

    // sequencer: owns both handshakes and walks the recompute steps
    a555_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_opcode),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .enable   (enable_reg),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: waveform state, arithmetic units and the sample register
    a555_dp #(
        .PHASE_BITS   (PHASE_BITS),
        .SUPPLY_LEVEL (SUPPLY_LEVEL)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .s_control_voltage (s_control_voltage),
        .charge_ns         (charge_reg),
        .discharge_ns      (discharge_reg),
        .rate_hz           (rate_reg),
        .amp               (amp_reg),
        .sample            (m_sample)
    );

endmodule

>>> rtl/a555_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a555_ctrl
// Sequencer: handshakes, tick dispatch and the waveform recompute steps.
// ----------------------------------------------------------------------------
module a555_ctrl
    import a555_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    input  logic  s_opcode,
    output logic  s_ready,
    output logic  m_valid,
    input  logic  m_ready,
    input  logic  enable,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE) && (!out_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_ready) out_valid_next = 1'b0;
        if (accept && s_opcode) out_valid_next = 1'b1;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && !s_opcode && enable && stat.cv_changed) state_next = ST_CHECK;
            end
            ST_CHECK:    state_next = stat.cv_silent ? ST_IDLE : ST_NORM_NUM;
            ST_NORM_NUM: if (stat.norm_done) state_next = ST_SQR_NUM;
            ST_SQR_NUM:  if (stat.cnt_zero) state_next = ST_LOAD_DEN;
            ST_LOAD_DEN: state_next = ST_NORM_DEN;
            ST_NORM_DEN: if (stat.norm_done) state_next = ST_SQR_DEN;
            ST_SQR_DEN:  if (stat.cnt_zero) state_next = ST_LN_MUL;
            ST_LN_MUL:   state_next = ST_HIGH_MUL;
            ST_HIGH_MUL: state_next = ST_TOTAL;
            ST_TOTAL:    state_next = ST_DUTY_CHK;
            ST_DUTY_CHK: begin
                if (stat.total_bad)      state_next = ST_IDLE;
                else if (stat.high_full) state_next = ST_D_MUL;
                else                     state_next = ST_DUTY_DIV;
            end
            ST_DUTY_DIV: if (stat.cnt_zero) state_next = ST_D_MUL;
            ST_D_MUL:    state_next = ST_PDIV;
            ST_PDIV:     if (stat.cnt_zero) state_next = ST_COMMIT;
            ST_COMMIT:   state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.tick    = accept && s_opcode;
                cmd.capture = accept && !s_opcode && enable && stat.cv_changed;
            end
            ST_CHECK: begin
                cmd.silence  = stat.cv_silent;
                cmd.load_num = !stat.cv_silent;
            end
            ST_NORM_NUM, ST_NORM_DEN: begin
                cmd.sqr_init  = stat.norm_done;
                cmd.norm_step = !stat.norm_done;
            end
            ST_SQR_NUM, ST_SQR_DEN: cmd.sqr_step = 1'b1;
            ST_LOAD_DEN: cmd.load_den  = 1'b1;
            ST_LN_MUL:   cmd.ln_mul    = 1'b1;
            ST_HIGH_MUL: cmd.high_mul  = 1'b1;
            ST_TOTAL:    cmd.total_add = 1'b1;
            ST_DUTY_CHK: begin
                cmd.silence   = stat.total_bad;
                cmd.duty_full = !stat.total_bad && stat.high_full;
                cmd.duty_init = !stat.total_bad && !stat.high_full;
            end
            ST_DUTY_DIV: cmd.duty_step = 1'b1;
            ST_D_MUL:    cmd.d_mul     = 1'b1;
            ST_PDIV:     cmd.div_step  = 1'b1;
            ST_COMMIT:   cmd.commit    = 1'b1;
            default:     cmd = '0;
        endcase
    end

endmodule

>>> rtl/a555_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a555_dp
// Datapath: log2 by squaring, duty and phase-step dividers, tick generator.
// ----------------------------------------------------------------------------
module a555_dp
    import a555_pkg::*;
#(
    parameter int PHASE_BITS   = 32,
    parameter int SUPPLY_LEVEL = 20480
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                cmd,
    output stat_t               stat,
    input  logic [15:0]         s_control_voltage,
    input  logic [26:0]         charge_ns,
    input  logic [26:0]         discharge_ns,
    input  logic [17:0]         rate_hz,
    input  logic [14:0]         amp,
    output logic signed [15:0]  sample
);

    localparam int          DIVW = 30 + PHASE_BITS;
    localparam int          CNTW = $clog2(DIVW);
    localparam logic [16:0] SUP  = 17'(SUPPLY_LEVEL);

    logic [15:0]           cv_reg, cv_next, last_reg, last_next;
    logic [30:0]           m_reg, m_next;
    logic [4:0]            k_reg, k_next;
    logic [28:0]           res_reg, res_next, lognum_reg, lognum_next;
    logic [28:0]           lnv_reg, lnv_next;
    logic [31:0]           high_reg, high_next;
    logic [32:0]           total_reg, total_next, drem_reg, drem_next;
    logic [15:0]           dq_reg, dq_next, duty_reg, duty_next;
    logic [50:0]           d_reg, d_next, prem_reg, prem_next;
    logic [DIVW-1:0]       dvd_reg, dvd_next;
    logic [PHASE_BITS-1:0] q_reg, q_next, step_reg, step_next, phase_reg, phase_next;
    logic                  sat_reg, sat_next;
    logic [CNTW-1:0]       cnt_reg, cnt_next;
    logic [15:0]           sample_reg, sample_next;

    logic [16:0] cv17, num, den;
    logic [61:0] sq;
    logic [31:0] sq_top;
    logic [28:0] diff;
    logic [58:0] ln_prod;
    logic [55:0] high_prod;
    logic [33:0] dr2;
    logic        dge;
    logic [51:0] pr2;
    logic        pge;
    logic [15:0] amp16;

    assign cv17      = {1'b0, cv_reg};
    assign num       = 17'(SUP << 1) - cv17;
    assign den       = 17'((SUP - cv17) << 1);
    assign sq        = {31'd0, m_reg} * {31'd0, m_reg};
    assign sq_top    = sq[61:30];
    assign diff      = lognum_reg - res_reg;
    assign ln_prod   = {30'd0, diff} * {29'd0, LN2_Q30};
    assign high_prod = {29'd0, charge_ns} * {27'd0, lnv_reg};
    assign dr2       = {drem_reg, 1'b0};
    assign dge       = dr2 >= {1'b0, total_reg};
    assign pr2       = {prem_reg, dvd_reg[DIVW-1]};
    assign pge       = pr2 >= {1'b0, d_reg};
    assign amp16     = {1'b0, amp};

    assign stat.cv_changed = s_control_voltage != last_reg;
    assign stat.cv_silent  = (cv_reg >= SILENCE_LEVEL) || (cv17 >= SUP);
    assign stat.norm_done  = m_reg[30];
    assign stat.cnt_zero   = cnt_reg == '0;
    assign stat.total_bad  = (total_reg == '0) || (rate_hz == '0);
    assign stat.high_full  = {1'b0, high_reg} >= total_reg;

    assign sample = sample_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg  <= '0;
            duty_reg  <= '0;
            step_reg  <= '0;
            phase_reg <= '0;
        end else begin
            last_reg  <= last_next;
            duty_reg  <= duty_next;
            step_reg  <= step_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        cv_reg     <= cv_next;
        m_reg      <= m_next;
        k_reg      <= k_next;
        res_reg    <= res_next;
        lognum_reg <= lognum_next;
        lnv_reg    <= lnv_next;
        high_reg   <= high_next;
        total_reg  <= total_next;
        drem_reg   <= drem_next;
        dq_reg     <= dq_next;
        d_reg      <= d_next;
        prem_reg   <= prem_next;
        dvd_reg    <= dvd_next;
        q_reg      <= q_next;
        sat_reg    <= sat_next;
        cnt_reg    <= cnt_next;
        sample_reg <= sample_next;
    end

    always_comb begin
        cv_next     = cv_reg;
        last_next   = last_reg;
        m_next      = m_reg;
        k_next      = k_reg;
        res_next    = res_reg;
        lognum_next = lognum_reg;
        lnv_next    = lnv_reg;
        high_next   = high_reg;
        total_next  = total_reg;
        drem_next   = drem_reg;
        dq_next     = dq_reg;
        d_next      = d_reg;
        prem_next   = prem_reg;
        dvd_next    = dvd_reg;
        q_next      = q_reg;
        sat_next    = sat_reg;
        cnt_next    = cnt_reg;
        duty_next   = duty_reg;
        step_next   = step_reg;
        phase_next  = phase_reg;
        sample_next = sample_reg;

        if (cmd.capture) begin
            cv_next   = s_control_voltage;
            last_next = s_control_voltage;
        end
        if (cmd.load_num) begin
            m_next = {14'd0, num};
            k_next = 5'd30;
        end
        if (cmd.load_den) begin
            m_next      = {14'd0, den};
            k_next      = 5'd30;
            lognum_next = res_reg;
        end
        // shift the mantissa up until its leading one reaches the top
        if (cmd.norm_step) begin
            m_next = {m_reg[29:0], 1'b0};
            k_next = k_reg - 5'd1;
        end
        if (cmd.sqr_init) begin
            res_next = {k_reg, 24'd0};
            cnt_next = CNTW'(SQR_LAST);
        end
        // one fraction bit per squaring
        if (cmd.sqr_step) begin
            if (sq_top[31]) begin
                m_next   = sq_top[31:1];
                res_next = res_reg | (29'd1 << cnt_reg);
            end else begin
                m_next = sq_top[30:0];
            end
            cnt_next = cnt_reg - CNTW'(1);
        end
        if (cmd.ln_mul)    lnv_next   = ln_prod[58:30];
        if (cmd.high_mul)  high_next  = high_prod[55:24];
        if (cmd.total_add) total_next = {1'b0, high_reg} + {6'd0, discharge_ns};
        if (cmd.duty_full) dq_next    = 16'hFFFF;
        if (cmd.duty_init) begin
            drem_next = {1'b0, high_reg};
            dq_next   = '0;
            cnt_next  = CNTW'(DUTY_LAST);
        end
        if (cmd.duty_step) begin
            drem_next = dge ? 33'(dr2 - {1'b0, total_reg}) : dr2[32:0];
            dq_next   = {dq_reg[14:0], dge};
            cnt_next  = cnt_reg - CNTW'(1);
        end
        if (cmd.d_mul) begin
            d_next    = 51'({33'd0, rate_hz} * {18'd0, total_reg});
            prem_next = '0;
            dvd_next  = {NS_PER_S, {PHASE_BITS{1'b0}}};
            q_next    = '0;
            sat_next  = 1'b0;
            cnt_next  = CNTW'(DIVW - 1);
        end
        // restoring division; flag overflow of the quotient field
        if (cmd.div_step) begin
            prem_next = pge ? 51'(pr2 - {1'b0, d_reg}) : pr2[50:0];
            dvd_next  = {dvd_reg[DIVW-2:0], 1'b0};
            q_next    = {q_reg[PHASE_BITS-2:0], pge};
            sat_next  = sat_reg | q_reg[PHASE_BITS-1];
            cnt_next  = cnt_reg - CNTW'(1);
        end
        if (cmd.commit) begin
            duty_next = dq_reg;
            step_next = sat_reg ? {PHASE_BITS{1'b1}} : q_reg;
        end
        if (cmd.silence) begin
            duty_next = '0;
            step_next = '0;
        end
        if (cmd.tick) begin
            if (step_reg == '0) begin
                sample_next = '0;
            end else begin
                sample_next = (phase_reg[PHASE_BITS-1 -: 16] < duty_reg) ? amp16 : 16'(-amp16);
                phase_next  = phase_reg + step_reg;
            end
        end
    end

`ifndef SYNTH
    a_norm_mantissa: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sqr_step |-> m_reg[30])
        else $error("squaring with unnormalised mantissa");
    a_duty_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.duty_step |-> (drem_reg < total_reg))
        else $error("duty remainder not below period");
    a_phase_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> (prem_reg < d_reg))
        else $error("phase-step remainder not below divisor");
    a_silent_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.tick && step_reg == '0) |=> $stable(phase_reg))
        else $error("phase moved while silent");
`endif

endmodule
